/* rtl/atsse_pkg.sv */
package atsse_pkg;

    localparam int DEPTH = 64;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        ACT_CLEAR  = 4'd0,
        ACT_APPEND = 4'd1,
        ACT_READ   = 4'd2,
        ACT_INSERT = 4'd3,
        ACT_UPDATE = 4'd4,
        ACT_DELETE = 4'd5,
        ACT_SORTDN = 4'd6,
        ACT_SORTUP = 4'd7,
        ACT_LFIND  = 4'd8,
        ACT_BFIND  = 4'd9
    } action_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    typedef struct packed {
        logic [3:0]         action;
        logic [6:0]         position;
        logic signed [31:0] operand;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [5:0]         index;
        logic signed [31:0] element;
        logic               last;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,      // read issued for addr, wait
        S_RDUSE,   // data valid
        S_SHUP,    // insert shift: read i-1
        S_SHUPW,   // write i
        S_SHDN,    // delete: removed value valid, read i+1
        S_SHDNR,   // delete shift: read i+1
        S_SHDNW,   // delete shift: write i
        S_SRDI,    // sort: read i
        S_SRDJ,    // sort: ei valid, read j
        S_SCMP,    // compare ei, ej
        S_SWPJ,    // next j, or write ei back to i
        S_BPROBE,
        S_BCMP,
        S_DONE
    } state_t;

endpackage

/* rtl/atsse_ram.sv */
module atsse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

/* rtl/array_table_sort_search_engine_top.sv */
// channel | dir | handshake              | word
// cmd     | in  | start & !busy          | atsse_pkg::cmd_t
// rsp     | out | strobe (one cycle)     | atsse_pkg::rsp_t
// Clear/append/update/rejected words answer next cycle, busy stays low.
// Read all, linear find, insert and delete step through the elements; the sorts
// use one comparator and one RAM port; binary find is the ascending sort
// followed by its probes.
// Reset: count cleared; element RAM is not cleared and needs no pass.
// Stalls: none; the receiver takes every result in its strobe cycle.
module array_table_sort_search_engine_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  atsse_pkg::cmd_t  cmd,
    output logic             strobe,
    output atsse_pkg::rsp_t  rsp
);
    import atsse_pkg::*;

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next;
    logic signed [7:0] lo_reg, lo_next, hi_reg, hi_next;
    logic signed [31:0] ei_reg, ei_next;
    logic [AW-1:0] pend_reg, pend_next;
    cmd_t cmd_reg, cmd_next;
    logic [AW-1:0] addr;
    logic we;
    logic signed [31:0] wdata, rdata;
    logic strobe_reg, strobe_next;
    rsp_t rsp_reg, rsp_next;
    logic swap_it, hit, lt;
    logic signed [7:0] mid;
    logic pos_ok, ins_ok, i_last, j_last, shdn_last;

    atsse_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    assign busy = (state_reg != S_IDLE);
    assign strobe = strobe_reg;
    assign rsp = rsp_reg;

    // shared comparator and loop bounds
    always_comb
    begin
        if (cmd_reg.action == ACT_SORTDN)
        begin
            swap_it = (ei_reg < rdata);
        end
        else
        begin
            swap_it = (rdata < ei_reg);
        end
        mid = (lo_reg + hi_reg) >>> 1;
        hit = (rdata == cmd_reg.operand);
        lt  = (rdata < cmd_reg.operand);
        pos_ok = (CW'(cmd.position) < count_reg);
        ins_ok = (CW'(cmd.position) <= count_reg) && (count_reg < CW'(DEPTH));
        i_last = (i_reg + CW'(1) >= count_reg);
        j_last = (j_reg + CW'(1) >= count_reg);
        shdn_last = (i_reg + CW'(2) >= count_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            strobe_reg <= 1'b0;
            i_reg      <= '0;
            j_reg      <= '0;
            lo_reg     <= '0;
            hi_reg     <= '0;
            ei_reg     <= '0;
            pend_reg   <= '0;
            cmd_reg    <= '0;
            rsp_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            strobe_reg <= strobe_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            ei_reg     <= ei_next;
            pend_reg   <= pend_next;
            cmd_reg    <= cmd_next;
            rsp_reg    <= rsp_next;
        end
    end

    // sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (cmd.action)
                        ACT_READ:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = S_RD;
                            end
                        end
                        ACT_LFIND:
                        begin
                            state_next = (count_reg == '0) ? S_DONE : S_RD;
                        end
                        ACT_INSERT:
                        begin
                            if (ins_ok)
                            begin
                                state_next = S_SHUP;
                            end
                        end
                        ACT_DELETE:
                        begin
                            if (pos_ok)
                            begin
                                state_next = S_SHDN;
                            end
                        end
                        ACT_SORTDN, ACT_SORTUP, ACT_BFIND:
                        begin
                            state_next = S_SRDI;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RD:
            begin
                state_next = S_RDUSE;
            end
            S_RDUSE:
            begin
                if (i_last)
                begin
                    state_next = (cmd_reg.action == ACT_READ) ? S_IDLE : S_DONE;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            S_SHUP:
            begin
                state_next = (i_reg == CW'(cmd_reg.position)) ? S_IDLE : S_SHUPW;
            end
            S_SHUPW:
            begin
                state_next = S_SHUP;
            end
            S_SHDN:
            begin
                state_next = i_last ? S_IDLE : S_SHDNW;
            end
            S_SHDNR:
            begin
                state_next = S_SHDNW;
            end
            S_SHDNW:
            begin
                state_next = shdn_last ? S_IDLE : S_SHDNR;
            end
            S_SRDI:
            begin
                if (i_last)
                begin
                    state_next = (cmd_reg.action == ACT_BFIND) ? S_BPROBE : S_IDLE;
                end
                else
                begin
                    state_next = S_SRDJ;
                end
            end
            S_SRDJ:
            begin
                state_next = S_SCMP;
            end
            S_SCMP:
            begin
                if (swap_it || j_last)
                begin
                    state_next = S_SWPJ;
                end
            end
            S_SWPJ:
            begin
                state_next = j_last ? S_SRDI : S_SCMP;
            end
            S_BPROBE:
            begin
                state_next = (lo_reg > hi_reg) ? S_IDLE : S_BCMP;
            end
            S_BCMP:
            begin
                state_next = hit ? S_IDLE : S_BPROBE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer: datapath, RAM port and results
    always_comb
    begin
        count_next  = count_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        ei_next     = ei_reg;
        pend_next   = pend_reg;
        cmd_next    = cmd_reg;
        strobe_next = 1'b0;
        rsp_next    = rsp_reg;
        we          = 1'b0;
        addr        = i_reg[AW-1:0];
        wdata       = ei_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    strobe_next = 1'b1;
                    rsp_next = '{ST_INVALID, 6'd0, 32'sd0, 1'b1};
                    case (cmd.action)
                        ACT_CLEAR:
                        begin
                            count_next = '0;
                            rsp_next.status = ST_OK;
                        end
                        ACT_APPEND:
                        begin
                            if (count_reg < CW'(DEPTH))
                            begin
                                we = 1'b1;
                                addr = count_reg[AW-1:0];
                                wdata = cmd.operand;
                                rsp_next = '{ST_OK, 6'(count_reg), cmd.operand, 1'b1};
                                count_next = count_reg + CW'(1);
                            end
                        end
                        ACT_UPDATE:
                        begin
                            if (pos_ok)
                            begin
                                we = 1'b1;
                                addr = cmd.position[AW-1:0];
                                wdata = cmd.operand;
                                rsp_next = '{ST_OK, 6'(cmd.position), cmd.operand, 1'b1};
                            end
                        end
                        ACT_READ:
                        begin
                            if (count_reg == '0)
                            begin
                                rsp_next.status = ST_NOTFOUND;
                            end
                            else
                            begin
                                strobe_next = 1'b0;
                                i_next = '0;
                                addr = '0;
                            end
                        end
                        ACT_LFIND:
                        begin
                            strobe_next = 1'b0;
                            i_next = '0;
                            j_next = '0;
                            addr = '0;
                        end
                        ACT_INSERT:
                        begin
                            if (ins_ok)
                            begin
                                strobe_next = 1'b0;
                                i_next = count_reg;
                            end
                        end
                        ACT_DELETE:
                        begin
                            if (pos_ok)
                            begin
                                strobe_next = 1'b0;
                                i_next = CW'(cmd.position);
                                addr = cmd.position[AW-1:0];
                            end
                        end
                        ACT_SORTDN, ACT_SORTUP, ACT_BFIND:
                        begin
                            strobe_next = 1'b0;
                            i_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RDUSE:
            begin
                // read-all or linear find, rdata = elements[i]
                if (cmd_reg.action == ACT_READ)
                begin
                    strobe_next = 1'b1;
                    rsp_next = '{ST_OK, 6'(i_reg), rdata, i_last};
                end
                else if (hit)
                begin
                    // emit the previous match, hold this one until the next
                    if (j_reg != '0)
                    begin
                        strobe_next = 1'b1;
                        rsp_next = '{ST_OK, pend_reg, cmd_reg.operand, 1'b0};
                    end
                    pend_next = i_reg[AW-1:0];
                    j_next = CW'(1);
                end
                if (!i_last)
                begin
                    i_next = i_reg + CW'(1);
                    addr = AW'(i_reg + CW'(1));
                end
            end
            S_DONE:
            begin
                // linear find close-out
                strobe_next = 1'b1;
                if (j_reg == '0)
                begin
                    rsp_next = '{ST_NOTFOUND, 6'd0, cmd_reg.operand, 1'b1};
                end
                else
                begin
                    rsp_next = '{ST_OK, pend_reg, cmd_reg.operand, 1'b1};
                end
            end
            S_SHUP:
            begin
                if (i_reg == CW'(cmd_reg.position))
                begin
                    we = 1'b1;
                    wdata = cmd_reg.operand;
                    count_next = count_reg + CW'(1);
                    strobe_next = 1'b1;
                    rsp_next = '{ST_OK, 6'(i_reg), cmd_reg.operand, 1'b1};
                end
                else
                begin
                    addr = AW'(i_reg - CW'(1));
                end
            end
            S_SHUPW:
            begin
                we = 1'b1;
                wdata = rdata;
                i_next = i_reg - CW'(1);
            end
            S_SHDN:
            begin
                // rdata = removed element
                ei_next = rdata;
                if (i_last)
                begin
                    count_next = count_reg - CW'(1);
                    strobe_next = 1'b1;
                    rsp_next = '{ST_OK, 6'(cmd_reg.position), rdata, 1'b1};
                end
                else
                begin
                    addr = AW'(i_reg + CW'(1));
                end
            end
            S_SHDNR:
            begin
                addr = AW'(i_reg + CW'(1));
            end
            S_SHDNW:
            begin
                // rdata = elements[i+1], written into i
                we = 1'b1;
                wdata = rdata;
                if (shdn_last)
                begin
                    count_next = count_reg - CW'(1);
                    strobe_next = 1'b1;
                    rsp_next = '{ST_OK, 6'(cmd_reg.position), ei_reg, 1'b1};
                end
                else
                begin
                    i_next = i_reg + CW'(1);
                end
            end
            S_SRDI:
            begin
                if (i_last)
                begin
                    if (cmd_reg.action == ACT_BFIND)
                    begin
                        lo_next = 8'sd0;
                        hi_next = $signed(8'(count_reg)) - 8'sd1;
                    end
                    else
                    begin
                        strobe_next = 1'b1;
                        rsp_next = '{ST_OK, 6'd0, 32'sd0, 1'b1};
                    end
                end
                else
                begin
                    j_next = i_reg + CW'(1);
                end
            end
            S_SRDJ:
            begin
                // rdata = elements[i], loaded into ei before j runs
                ei_next = rdata;
                addr = j_reg[AW-1:0];
            end
            S_SCMP:
            begin
                if (swap_it)
                begin
                    we = 1'b1;
                    addr = j_reg[AW-1:0];
                    wdata = ei_reg;
                    ei_next = rdata;
                end
                else if (!j_last)
                begin
                    j_next = j_reg + CW'(1);
                    addr = AW'(j_reg + CW'(1));
                end
            end
            S_SWPJ:
            begin
                if (j_last)
                begin
                    // write current min/max back to slot i
                    we = 1'b1;
                    wdata = ei_reg;
                    i_next = i_reg + CW'(1);
                end
                else
                begin
                    j_next = j_reg + CW'(1);
                    addr = AW'(j_reg + CW'(1));
                end
            end
            S_BPROBE:
            begin
                if (lo_reg > hi_reg)
                begin
                    strobe_next = 1'b1;
                    rsp_next = '{ST_NOTFOUND, 6'd0, cmd_reg.operand, 1'b1};
                end
                else
                begin
                    addr = mid[AW-1:0];
                end
            end
            S_BCMP:
            begin
                if (hit)
                begin
                    strobe_next = 1'b1;
                    rsp_next = '{ST_OK, 6'(mid), rdata, 1'b1};
                end
                else if (lt)
                begin
                    lo_next = mid + 8'sd1;
                end
                else
                begin
                    hi_next = mid - 8'sd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH)) else $error("count beyond depth");
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !start) |=> !strobe)
        else $error("strobe without work");
    a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.action == ACT_CLEAR) |=> (count_reg == '0 && strobe))
        else $error("clear failed");

endmodule
